// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the resampler RTL.
// Each macro takes a label, clock, reset, antecedent and consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons)
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/prh_pkg.sv =====
package prh_pkg;

   // Operation codes of an input transfer
   typedef enum logic [1:0] {
      OP_COEFF   = 2'd0,
      OP_OFFSET  = 2'd1,
      OP_SAMPLE  = 2'd2,
      OP_COMPUTE = 2'd3
   } op_type;

   // Controller to datapath commands
   typedef struct packed {
      logic write_coeff;
      logic write_offset;
      logic write_sample;
      logic start_compute;
      logic load_base;
      logic issue;
      logic finish;
   } cmd_type;

   // Rounding and output range, Q14
   localparam logic [31:0]        ROUND_BIAS = 32'h0000_2000;
   localparam int unsigned        Q_SHIFT    = 14;
   localparam logic signed [31:0] PIX_MAX    = 32'sd32767;
   localparam logic signed [31:0] PIX_MIN    = -32'sd32768;
   localparam logic [15:0]        SIGN_FLIP  = 16'h8000;
   localparam logic [4:0]         TAP_COUNT_RESET = 5'd8;

   // Remainder by a constant modulus through restoring compare and subtract.
   // Values here stay below 256 times the modulus.
   function automatic logic [15:0] wrap_index(input logic [15:0] value,
                                              input int unsigned modulus);
      logic [15:0] v;
      int unsigned step;
      v = value;
      for (int j = 7; j >= 0; j--) begin
         step = modulus << j;
         if (32'(v) >= step) begin
            v = v - 16'(step);
         end
      end
      return v;
   endfunction

endpackage

// ===== rtl/core/polyphase_resize_u16_horizontal.sv =====
// Channel    | Ports                                   | Transfer
// -----------+-----------------------------------------+---------------------------
// request    | start, busy, req_*                      | start high, busy low
// result     | rsp_valid, rsp_pixel, rsp_pixel_position| rsp_valid high, one cycle
// csr        | csr_write_enable, csr_write_data        | csr_write_enable high
//
// Writes (coefficient, offset, sample) leave busy low. A compute transfer
// holds busy (tap_count saturated to MAX_TAPS) through one offset read, one
// tap per cycle on the shared multiplier, the pipeline drain states and a
// rounding state; rsp_valid follows.
// Reset is synchronous; the stores come up undefined and are not cleared.
// The result register frees the request side: a new transfer may be taken in
// the cycle its predecessor's result is shown. The receiver cannot stall.
`include "assert_macros.svh"

module polyphase_resize_u16_horizontal #(
   parameter int OUT_WIDTH = 64,
   parameter int MAX_TAPS  = 16,
   parameter int SRC_WIDTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [5:0]         req_out_index,
   input  logic [3:0]         req_tap_index,
   input  logic signed [15:0] req_coeff,
   input  logic [7:0]         req_left_offset,
   input  logic [7:0]         req_src_position,
   input  logic [15:0]        req_sample,
   output logic               rsp_valid,
   output logic [15:0]        rsp_pixel,
   output logic [5:0]         rsp_pixel_position,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_write_data
);
   import prh_pkg::*;

   localparam int KW = $clog2(MAX_TAPS);

   cmd_type       cmd;
   logic [KW-1:0] tap_k;
   op_type        op;

   assign op = op_type'(req_op);

   prh_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_op           (op),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .busy             (busy),
      .cmd              (cmd),
      .tap_k            (tap_k)
   );

   prh_datapath #(
      .OUT_WIDTH (OUT_WIDTH),
      .MAX_TAPS  (MAX_TAPS),
      .SRC_WIDTH (SRC_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .tap_k              (tap_k),
      .req_out_index      (req_out_index),
      .req_tap_index      (req_tap_index),
      .req_coeff          (req_coeff),
      .req_left_offset    (req_left_offset),
      .req_src_position   (req_src_position),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_pixel          (rsp_pixel),
      .rsp_pixel_position (rsp_pixel_position)
   );

   // Checks
   `ASSERT_NEXT_CYCLE(a_compute_goes_busy, clock, reset, start && !busy && op == OP_COMPUTE, busy)
   `ASSERT_NEXT_CYCLE(a_write_stays_free, clock, reset, start && !busy && op != OP_COMPUTE, !busy)
   `ASSERT_NEXT_CYCLE(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `ASSERT_SAME_CYCLE(a_strobe_when_free, clock, reset, rsp_valid, !busy)
   `ASSERT_SAME_CYCLE(a_one_phase, clock, reset, 1'b1, $onehot0({cmd.load_base, cmd.issue, cmd.finish}))

endmodule

// ===== rtl/core/prh_ram.sv =====
module prh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/prh_ctrl.sv =====
module prh_ctrl #(
   parameter int MAX_TAPS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  prh_pkg::op_type             req_op,
   input  logic                        csr_write_enable,
   input  logic [4:0]                  csr_write_data,
   output logic                        busy,
   output prh_pkg::cmd_type            cmd,
   output logic [$clog2(MAX_TAPS)-1:0] tap_k
);
   import prh_pkg::*;

   localparam int TW = $clog2(MAX_TAPS + 1);
   localparam int KW = $clog2(MAX_TAPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OFFSET,
      ST_RUN,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_DONE
   } state_type;

   state_type      state_ff, state_in;
   logic [4:0]     tap_count_ff, tap_count_in;
   logic [TW-1:0]  taps_ff, taps_in;
   logic [TW-1:0]  k_ff, k_in;
   logic           busy_ff, busy_in;
   logic           accept;

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;
   assign tap_k  = k_ff[KW-1:0];

   // Next state, counters and commands
   always_comb begin
      state_in     = state_ff;
      tap_count_in = tap_count_ff;
      taps_in      = taps_ff;
      k_in         = k_ff;
      cmd          = '0;

      if (csr_write_enable) begin
         tap_count_in = csr_write_data;
      end

      cmd.write_coeff   = accept && (req_op == OP_COEFF);
      cmd.write_offset  = accept && (req_op == OP_OFFSET);
      cmd.write_sample  = accept && (req_op == OP_SAMPLE);
      cmd.start_compute = accept && (req_op == OP_COMPUTE);

      case (state_ff)
         ST_IDLE: begin
            if (cmd.start_compute) begin
               // saturate the tap count to the coefficient row length
               taps_in  = (int'(tap_count_ff) > MAX_TAPS) ? TW'(MAX_TAPS)
                                                          : TW'(tap_count_ff);
               state_in = ST_OFFSET;
            end
         end
         ST_OFFSET: begin
            cmd.load_base = 1'b1;
            k_in          = '0;
            state_in      = (taps_ff == '0) ? ST_DRAIN1 : ST_RUN;
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            k_in      = k_ff + TW'(1);
            if (k_ff == taps_ff - TW'(1)) begin
               state_in = ST_DRAIN1;
            end
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_DONE;
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      busy_in = (state_in != ST_IDLE);
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_count_ff <= TAP_COUNT_RESET;
         taps_ff      <= '0;
         k_ff         <= '0;
         busy_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_count_ff <= tap_count_in;
         taps_ff      <= taps_in;
         k_ff         <= k_in;
         busy_ff      <= busy_in;
      end
   end

endmodule

// ===== rtl/core/prh_datapath.sv =====
module prh_datapath #(
   parameter int OUT_WIDTH = 64,
   parameter int MAX_TAPS  = 16,
   parameter int SRC_WIDTH = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  prh_pkg::cmd_type            cmd,
   input  logic [$clog2(MAX_TAPS)-1:0] tap_k,
   input  logic [5:0]                  req_out_index,
   input  logic [3:0]                  req_tap_index,
   input  logic signed [15:0]          req_coeff,
   input  logic [7:0]                  req_left_offset,
   input  logic [7:0]                  req_src_position,
   input  logic [15:0]                 req_sample,
   output logic                        rsp_valid,
   output logic [15:0]                 rsp_pixel,
   output logic [5:0]                  rsp_pixel_position
);
   import prh_pkg::*;

   localparam int OW = $clog2(OUT_WIDTH);
   localparam int SW = $clog2(SRC_WIDTH);
   localparam int CW = $clog2(OUT_WIDTH * MAX_TAPS);
   localparam int KW = $clog2(MAX_TAPS);

   logic [15:0]        pos_wide, tap_wide, src_wide, base_wide;
   logic [OW-1:0]      pos;
   logic [KW-1:0]      tap_sel;
   logic [SW-1:0]      src_addr;
   logic [CW-1:0]      row_base;
   logic [CW-1:0]      coeff_wr_addr, coeff_rd_addr;
   logic [15:0]        coeff_rd;
   logic [7:0]         offset_rd;
   logic [15:0]        sample_rd;

   logic [CW-1:0]      coeff_base_ff, coeff_base_in;
   logic [SW-1:0]      line_addr_ff, line_addr_in;
   logic [5:0]         position_ff, position_in;
   logic               rd_valid_ff, prod_valid_ff, rsp_valid_ff;
   logic signed [31:0] prod_ff, prod_in;
   logic [31:0]        acc_ff, acc_in;
   logic [15:0]        pixel_ff, pixel_in;
   logic [31:0]        rounded;
   logic signed [31:0] shifted;

   // Index wrapping of the input fields and of the read left offset
   always_comb begin
      pos_wide = wrap_index({10'b0, req_out_index}, OUT_WIDTH);
      tap_wide = wrap_index({12'b0, req_tap_index}, MAX_TAPS);
      src_wide = wrap_index({8'b0, req_src_position}, SRC_WIDTH);
      base_wide = wrap_index({8'b0, offset_rd}, SRC_WIDTH);
   end

   assign pos           = pos_wide[OW-1:0];
   assign tap_sel       = tap_wide[KW-1:0];
   assign src_addr      = src_wide[SW-1:0];
   assign row_base      = CW'(pos) * CW'(MAX_TAPS);
   assign coeff_wr_addr = row_base + CW'(tap_sel);
   assign coeff_rd_addr = coeff_base_ff + CW'(tap_k);

   // Coefficient rows, one per output position
   prh_ram #(.WIDTH(16), .DEPTH(OUT_WIDTH * MAX_TAPS)) u_coeff_ram (
      .clock   (clock),
      .wr_en   (cmd.write_coeff),
      .wr_addr (coeff_wr_addr),
      .wr_data (req_coeff),
      .rd_addr (coeff_rd_addr),
      .rd_data (coeff_rd)
   );

   // Left offsets, read at the compute transfer
   prh_ram #(.WIDTH(8), .DEPTH(OUT_WIDTH)) u_offset_ram (
      .clock   (clock),
      .wr_en   (cmd.write_offset),
      .wr_addr (pos),
      .wr_data (req_left_offset),
      .rd_addr (pos),
      .rd_data (offset_rd)
   );

   // Source line buffer
   prh_ram #(.WIDTH(16), .DEPTH(SRC_WIDTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (cmd.write_sample),
      .wr_addr (src_addr),
      .wr_data (req_sample),
      .rd_addr (line_addr_ff),
      .rd_data (sample_rd)
   );

   // Address sequencing and MAC
   always_comb begin
      coeff_base_in = cmd.start_compute ? row_base : coeff_base_ff;
      position_in   = cmd.start_compute ? req_out_index : position_ff;

      line_addr_in = line_addr_ff;
      if (cmd.load_base) begin
         line_addr_in = base_wide[SW-1:0];
      end else if (cmd.issue) begin
         line_addr_in = (int'(line_addr_ff) == SRC_WIDTH - 1) ? '0
                                                               : line_addr_ff + SW'(1);
      end

      // bias the sample to signed, one 16x16 product per tap
      prod_in = $signed(coeff_rd) * $signed(sample_rd ^ SIGN_FLIP);

      acc_in = acc_ff;
      if (cmd.start_compute) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   // Round, saturate, unbias
   always_comb begin
      rounded = acc_ff + ROUND_BIAS;
      shifted = $signed(rounded) >>> Q_SHIFT;
      if (shifted > PIX_MAX) begin
         pixel_in = PIX_MAX[15:0] ^ SIGN_FLIP;
      end else if (shifted < PIX_MIN) begin
         pixel_in = PIX_MIN[15:0] ^ SIGN_FLIP;
      end else begin
         pixel_in = shifted[15:0] ^ SIGN_FLIP;
      end
   end

   // Pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff   <= cmd.issue;
         prod_valid_ff <= rd_valid_ff;
         rsp_valid_ff  <= cmd.finish;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      coeff_base_ff <= coeff_base_in;
      position_ff   <= position_in;
      line_addr_ff  <= line_addr_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      if (cmd.finish) begin
         pixel_ff <= pixel_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel          = pixel_ff;
   assign rsp_pixel_position = position_ff;

endmodule

// ===== dv/resample_checker.sv =====
module resample_checker #(
   parameter int OUT_WIDTH = 64,
   parameter int MAX_TAPS  = 16,
   parameter int SRC_WIDTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_op,
   input  logic [5:0]         req_out_index,
   input  logic [3:0]         req_tap_index,
   input  logic signed [15:0] req_coeff,
   input  logic [7:0]         req_left_offset,
   input  logic [7:0]         req_src_position,
   input  logic [15:0]        req_sample,
   input  logic               rsp_valid,
   input  logic [15:0]        rsp_pixel,
   input  logic [5:0]         rsp_pixel_position,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_write_data,
   output int                 pending_count,
   output int                 error_count,
   output int                 checked_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import prh_pkg::*;

   typedef struct packed {
      logic [15:0] pixel;
      logic [5:0]  position;
   } pixel_result_type;

   // Shadow copies of the filter state
   logic [15:0] coeff_mem  [OUT_WIDTH*MAX_TAPS];
   logic [7:0]  offset_mem [OUT_WIDTH];
   logic [15:0] line_mem   [SRC_WIDTH];
   logic [4:0]  tap_setting;

   pixel_result_type expected_pixels[$];

   initial begin
      pending_count = 0;
      error_count   = 0;
      checked_count = 0;
      tap_setting   = TAP_COUNT_RESET;
   end

   // Q14 multiply-accumulate over the taps, round, saturate, unbias
   function automatic logic [15:0] resample_pixel(input logic [5:0] position);
      int unsigned        taps;
      logic [7:0]         base;
      logic signed [15:0] weight;
      logic signed [15:0] level;
      logic signed [31:0] product;
      logic signed [31:0] rounded;
      logic [31:0]        acc;
      taps = (tap_setting > MAX_TAPS) ? MAX_TAPS : tap_setting;
      base = offset_mem[position];
      acc  = '0;
      for (int k = 0; k < taps; k++) begin
         weight  = coeff_mem[position * MAX_TAPS + k];
         level   = line_mem[(base + k) % SRC_WIDTH] ^ SIGN_FLIP;
         product = weight * level;
         acc     = acc + product;   // wraps at 32 bits
      end
      acc     = acc + ROUND_BIAS;
      rounded = $signed(acc) >>> Q_SHIFT;
      if (rounded > PIX_MAX) begin
         rounded = PIX_MAX;
      end else if (rounded < PIX_MIN) begin
         rounded = PIX_MIN;
      end
      return rounded[15:0] ^ SIGN_FLIP;
   endfunction

   always @(posedge clock) begin
      pixel_result_type head;
      if (reset) begin
         expected_pixels.delete();
         tap_setting = TAP_COUNT_RESET;
      end else begin
         // result side: compare before a new compute is queued
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t: unexpected pixel %0d at position %0d", $realtime,
                           rsp_pixel, rsp_pixel_position);
               end
            end else begin
               head = expected_pixels.pop_front();
               checked_count++;
               if (rsp_pixel !== head.pixel || rsp_pixel_position !== head.position) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("%0t: mismatch: expected pixel %0d pos %0d, got pixel %0d pos %0d",
                              $realtime, head.pixel, head.position, rsp_pixel,
                              rsp_pixel_position);
                  end
               end
            end
         end
         // request side
         if (start && !busy) begin
            case (op_type'(req_op))
               OP_COEFF: begin
                  coeff_mem[req_out_index * MAX_TAPS + req_tap_index] = req_coeff;
               end
               OP_OFFSET: begin
                  offset_mem[req_out_index] = req_left_offset;
               end
               OP_SAMPLE: begin
                  line_mem[req_src_position] = req_sample;
               end
               OP_COMPUTE: begin
                  expected_pixels.push_back('{pixel: resample_pixel(req_out_index),
                                              position: req_out_index});
               end
               default: ;
            endcase
         end
         if (csr_write_enable) begin
            tap_setting = csr_write_data;
         end
      end
      pending_count = expected_pixels.size();
   end

endmodule

// ===== dv/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import prh_pkg::*;

   localparam int OUT_WIDTH    = 64;
   localparam int MAX_TAPS     = 16;
   localparam int SRC_WIDTH    = 256;
   localparam int DRAIN_CYCLES = MAX_TAPS + 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 240;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_op;
   logic [5:0]         req_out_index;
   logic [3:0]         req_tap_index;
   logic signed [15:0] req_coeff;
   logic [7:0]         req_left_offset;
   logic [7:0]         req_src_position;
   logic [15:0]        req_sample;
   logic               rsp_valid;
   logic [15:0]        rsp_pixel;
   logic [5:0]         rsp_pixel_position;
   logic               csr_write_enable;
   logic [4:0]         csr_write_data;

   int pending_count;
   int error_count;
   int checked_count;
   int cycle_count = 0;
   int transfers_sent = 0;
   int settings_used = 0;
   int idle_pct = 0;

   // What has been written so far, so no compute reads an unwritten entry
   bit         coeff_seen  [OUT_WIDTH*MAX_TAPS];
   bit         offset_seen [OUT_WIDTH];
   bit         sample_seen [SRC_WIDTH];
   logic [7:0] offset_shadow [OUT_WIDTH];
   logic [4:0] tap_shadow;

   always #10 clock = ~clock;

   polyphase_resize_u16_horizontal #(
      .OUT_WIDTH(OUT_WIDTH),
      .MAX_TAPS (MAX_TAPS),
      .SRC_WIDTH(SRC_WIDTH)
   ) DUT (.*);

   resample_checker #(
      .OUT_WIDTH(OUT_WIDTH),
      .MAX_TAPS (MAX_TAPS),
      .SRC_WIDTH(SRC_WIDTH)
   ) scoreboard (.*);

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int taps_used();
      return (tap_shadow > MAX_TAPS) ? MAX_TAPS : tap_shadow;
   endfunction

   function automatic bit position_ready(input logic [5:0] pos);
      if (!offset_seen[pos]) begin
         return 1'b0;
      end
      for (int k = 0; k < taps_used(); k++) begin
         if (!coeff_seen[pos * MAX_TAPS + k]) return 1'b0;
         if (!sample_seen[(offset_shadow[pos] + k) % SRC_WIDTH]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit find_ready(output logic [5:0] pos);
      int first;
      first = $urandom_range(OUT_WIDTH - 1);
      for (int i = 0; i < OUT_WIDTH; i++) begin
         pos = 6'((first + i) % OUT_WIDTH);
         if (position_ready(pos)) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [15:0] coeff_value();
      case ($urandom_range(7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2, 3:    return 16'($urandom_range(8191)) - 16'd4096;
         4:       return 16'd16384 >> $urandom_range(4);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] sample_value();
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // One request transfer; fields the op ignores carry random values
   task automatic send_item(input op_type op, input logic [5:0] idx, input logic [3:0] tap,
                            input logic [15:0] coeff, input logic [7:0] off,
                            input logic [7:0] spos, input logic [15:0] smp);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_op           = op;
      req_out_index    = idx;
      req_tap_index    = tap;
      req_coeff        = coeff;
      req_left_offset  = off;
      req_src_position = spos;
      req_sample       = smp;
      start            = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      transfers_sent++;
   endtask

   task automatic put_coeff(input logic [5:0] pos, input logic [3:0] tap,
                            input logic [15:0] value);
      send_item(OP_COEFF, pos, tap, value, 8'($urandom), 8'($urandom), 16'($urandom));
      coeff_seen[pos * MAX_TAPS + tap] = 1'b1;
   endtask

   task automatic put_offset(input logic [5:0] pos, input logic [7:0] value);
      send_item(OP_OFFSET, pos, 4'($urandom), 16'($urandom), value, 8'($urandom),
                16'($urandom));
      offset_seen[pos]   = 1'b1;
      offset_shadow[pos] = value;
   endtask

   task automatic put_sample(input logic [7:0] spos, input logic [15:0] value);
      send_item(OP_SAMPLE, 6'($urandom), 4'($urandom), 16'($urandom), 8'($urandom), spos,
                value);
      sample_seen[spos] = 1'b1;
   endtask

   task automatic run_compute(input logic [5:0] pos);
      send_item(OP_COMPUTE, pos, 4'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                16'($urandom));
   endtask

   // Full setup of one output position followed by its compute
   task automatic program_position(input logic [5:0] pos);
      logic [7:0] off;
      off = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 240)) : 8'($urandom);
      put_offset(pos, off);
      for (int t = 0; t < MAX_TAPS; t++) begin
         put_coeff(pos, 4'(t), coeff_value());
      end
      for (int k = 0; k < taps_used(); k++) begin
         put_sample(8'(off + k), sample_value());
      end
      run_compute(pos);
   endtask

   // Let every pixel come out and the datapath settle
   task automatic wait_quiet();
      start = 1'b0;
      while (pending_count != 0 || busy) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_taps(input logic [4:0] value);
      wait_quiet();
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      tap_shadow       = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      settings_used++;
   endtask

   initial begin
      int         phase_taps [8] = '{16, 1, 31, 8, 17, 0, 4, 12};
      int         phase_idle [8] = '{0, 75, 28, 0, 75, 28, 0, 28};
      int         phase_first;
      int         steps;
      int         pick;
      logic [5:0] pos;

      reset            = 1'b1;
      start            = 1'b0;
      req_op           = OP_COEFF;
      req_out_index    = '0;
      req_tap_index    = '0;
      req_coeff        = '0;
      req_left_offset  = '0;
      req_src_position = '0;
      req_sample       = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      tap_shadow       = TAP_COUNT_RESET;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed: two taps, saturation both ways, window wrap, overflow, unity gain
      set_taps(5'd2);
      put_offset(6'd63, 8'd255);
      put_coeff(6'd63, 4'd0, 16'h7FFF);
      put_coeff(6'd63, 4'd1, 16'h7FFF);
      put_sample(8'd255, 16'hFFFF);
      put_sample(8'd0, 16'hFFFF);
      run_compute(6'd63);
      put_offset(6'd0, 8'd255);
      put_coeff(6'd0, 4'd0, 16'h8000);
      put_coeff(6'd0, 4'd1, 16'h8000);
      run_compute(6'd0);
      // both products +2^30: accumulator wraps negative
      put_sample(8'd255, 16'h0000);
      put_sample(8'd0, 16'h0000);
      run_compute(6'd0);
      run_compute(6'd63);
      put_offset(6'd1, 8'd0);
      put_coeff(6'd1, 4'd0, 16'd16384);
      put_coeff(6'd1, 4'd1, 16'd0);
      put_coeff(6'd1, 4'd15, 16'h7FFF);
      put_sample(8'd0, 16'd12345);
      put_sample(8'd1, 16'hFFFF);
      run_compute(6'd1);
      // zero taps gives mid-scale
      set_taps(5'd0);
      run_compute(6'd1);

      // Random phases over tap settings and idle rates
      for (int p = 0; p < 8; p++) begin
         set_taps(p == 5 ? 5'($urandom_range(31)) : 5'(phase_taps[p]));
         phase_first = transfers_sent;
         steps = 0;
         while (transfers_sent - phase_first < PHASE_ITEMS) begin
            // stretches without idling inside idling phases
            if (steps % 24 == 0) begin
               idle_pct = ($urandom_range(4) == 0) ? 0 : phase_idle[p];
            end
            steps++;
            pick = $urandom_range(99);
            if (pick < 8) begin
               program_position(6'($urandom));
            end else if (pick < 55) begin
               if (find_ready(pos)) begin
                  run_compute(pos);
               end else begin
                  program_position(6'($urandom));
               end
            end else if (pick < 75) begin
               put_sample(8'($urandom), sample_value());
            end else if (pick < 90) begin
               put_coeff(6'($urandom), 4'($urandom), coeff_value());
            end else begin
               put_offset(6'($urandom), 8'($urandom));
            end
         end
      end

      idle_pct = 0;
      wait_quiet();
      $display("Covered %0d transfers and %0d checked pixels over %0d tap-count settings,",
               transfers_sent, checked_count, settings_used);
      $display("with request idle rates of 0, 28 and 75 percent.");
      if (error_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
